// ===== rtl/set_assoc_cache_lru_lookup_top_defines.svh =====
// Assertion macros shared by the cache lookup RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (reset is active low).
`define SACL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SACL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SACL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SACL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/sacl_pkg.sv =====
// Shared types and constants of the set-associative cache lookup block.
// No dependencies; imported by the controller, datapath and top level.
package sacl_pkg;

    // Fixed port widths.
    localparam int ADDR_PORT_W = 32;
    localparam int CFG_W       = 4;
    localparam int CNT_W       = 32;
    localparam int SET_OUT_W   = 6;

    // Reset value of the ways-in-use register.
    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = 4'd8;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOOKUP
    } t_sacl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;
        logic load;
        logic div_step;
        logic rd_en;
        logic lookup;
    } t_sacl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic direct_set;
    } t_sacl_status;

endpackage

// ===== rtl/sacl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package or module dependencies.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/sacl_ctrl.sv =====
// Sequencer of the cache lookup: clearing pass, set reduction, read, update.
// Depends on sacl_pkg and the assertion macro header.
`include "set_assoc_cache_lru_lookup_top_defines.svh"

module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_sacl_status i_status,
    output t_sacl_cmd    o_cmd,
    output logic         o_busy
);

    t_sacl_state r_state;
    t_sacl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.direct_set ? ST_LOOKUP : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                // The quotient estimate is registered in this state.
                o_cmd.div_step = 1'b1;
                n_state        = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Only the idle state takes a new transfer.
    assign o_busy = (r_state != ST_IDLE);

    // An accepted transfer always moves on to reduction or lookup.
    `SACL_ASSERT(a_accept_moves, i_clk, i_rst_n, (r_state == ST_IDLE && i_start) |=> (r_state == ST_LOOKUP || r_state == ST_DIVIDE), "accepted item did not advance")
    // The update state is always followed by idle.
    `SACL_ASSERT(a_lookup_ends, i_clk, i_rst_n, (r_state == ST_LOOKUP) |=> (r_state == ST_IDLE), "lookup did not return to idle")
    // At most one command is issued per cycle.
    `SACL_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(o_cmd), "more than one datapath command")

endmodule

// ===== rtl/sacl_dpath.sv =====
// Datapath of the cache lookup: set/tag split, tag and LRU RAMs, counters.
// Depends on sacl_pkg, sacl_ram and the assertion macro header.
`include "set_assoc_cache_lru_lookup_top_defines.svh"

module sacl_dpath
    import sacl_pkg::*;
#(
    parameter int SETS        = 64,
    parameter int WAYS        = 8,
    parameter int OFFSET_BITS = 6,
    parameter int ADDR_BITS   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_sacl_cmd              i_cmd,
    output t_sacl_status           o_status,
    input  logic [ADDR_PORT_W-1:0] i_address,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    output logic                   o_done,
    output logic                   o_hit,
    output logic [SET_OUT_W-1:0]   o_set_index,
    output logic [CNT_W-1:0]       o_miss_total,
    output logic [CNT_W-1:0]       o_access_total
);

    localparam int  AW        = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
    localparam int  QW        = AW - OFFSET_BITS;
    localparam int  IW        = $clog2(SETS);
    localparam int  IW_S      = (IW > 0) ? IW : 1;
    localparam int  SHIFT     = OFFSET_BITS + IW;
    localparam int  TW        = AW - SHIFT;
    localparam int  TW_S      = (TW > 0) ? TW : 1;
    localparam int  RW        = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int  META_W    = WAYS * (1 + RW);
    localparam int  TAGROW_W  = WAYS * TW_S;
    localparam bit  SETS_POW2 = ((SETS & (SETS - 1)) == 0);

    // Reciprocal of the set count, exact for every block number of QW bits.
    localparam int              RSH        = QW + IW;
    localparam longint unsigned RECIP_FULL = ((64'd1 << RSH) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [QW:0]     RECIP      = (QW + 1)'(RECIP_FULL);

    // Request and configuration registers.
    logic [CFG_W-1:0] r_wiu;
    logic [IW_S-1:0]  r_set;
    logic [QW-1:0]    r_quot;
    logic [QW-1:0]    r_qhat;
    logic [TW_S-1:0]  r_tag;
    logic [IW_S-1:0]  r_clr_cnt;
    logic [CNT_W-1:0] r_miss;
    logic [CNT_W-1:0] r_acc;
    logic             r_done;
    logic             r_hit;
    logic [SET_OUT_W-1:0] r_set_out;

    logic [AW-1:0]    addr_m;
    logic [QW-1:0]    quot_in;
    logic [IW_S-1:0]  set_direct;
    logic [2*QW:0]    prod;
    logic [QW-1:0]    rem_full;
    logic [IW_S-1:0]  set_rem;

    // RAM ports.
    logic [IW_S-1:0]     rd_addr;
    logic                rd_en;
    logic [IW_S-1:0]     wr_addr;
    logic                meta_wr_en;
    logic [META_W-1:0]   meta_wr_data;
    logic [META_W-1:0]   meta_rd_data;
    logic                tag_wr_en;
    logic [TAGROW_W-1:0] tag_wr_data;
    logic [TAGROW_W-1:0] tag_rd_data;

    // Lookup results.
    logic [WAYS-1:0] valid_row;
    logic [RW-1:0]   rank [WAYS];
    logic [TW_S-1:0] tag_lane [WAYS];
    logic [WAYS-1:0] act;
    logic [WAYS-1:0] hit_vec;
    logic [WAYS-1:0] inv_vec;
    logic [WAYS-1:0] rank_seen;
    logic            hit;
    logic            any_inv;
    logic [RW-1:0]   hit_way;
    logic [RW-1:0]   inv_way;
    logic [RW-1:0]   vic_way;
    logic [RW-1:0]   max_rank;
    logic [RW-1:0]   used;
    logic [RW-1:0]   old_rank;
    logic            fill_all;
    logic [WAYS-1:0] new_valid;
    logic [RW-1:0]   new_rank [WAYS];

    // Address split: masked address, block number and tag.
    assign addr_m     = i_address[AW-1:0];
    assign quot_in    = addr_m[AW-1:OFFSET_BITS];
    assign set_direct = IW_S'(quot_in) & IW_S'(SETS - 1);

    // Set count that is not a power of two: the quotient comes from a reciprocal
    // multiplication in the divide state, and the remainder follows in the read cycle.
    assign prod     = (2 * QW + 1)'(r_quot) * (2 * QW + 1)'(RECIP);
    assign rem_full = r_quot - QW'(r_qhat * QW'(SETS));
    assign set_rem  = IW_S'(rem_full);

    assign o_status.direct_set = SETS_POW2;
    assign o_status.clr_last   = (r_clr_cnt == IW_S'(SETS - 1));

    // Ways-in-use register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiu <= WAYS_IN_USE_RESET;
        end else if (i_cfg_wr_en) begin
            r_wiu <= i_cfg_wr_data;
        end
    end

    // Request capture and set reduction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set  <= SETS_POW2 ? set_direct : '0;
            r_quot <= quot_in;
            r_tag  <= TW_S'(addr_m >> SHIFT);
        end else if (i_cmd.div_step) begin
            r_qhat <= QW'(prod >> RSH);
        end else if (i_cmd.rd_en) begin
            r_set  <= set_rem;
        end
    end

    // Clearing pass counter over the LRU rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + IW_S'(1);
        end
    end

    // RAM addressing: the read is issued at accept when the set is direct.
    assign rd_en   = i_cmd.load | i_cmd.rd_en;
    assign rd_addr = i_cmd.load ? set_direct : set_rem;
    assign wr_addr = i_cmd.clr_en ? r_clr_cnt : r_set;

    // Unpack the set row and evaluate hit, fill and victim.
    always_comb begin
        hit       = 1'b0;
        any_inv   = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        vic_way   = '0;
        max_rank  = '0;
        rank_seen = '0;
        for (int w = 0; w < WAYS; w++) begin
            valid_row[w] = meta_rd_data[w];
            rank[w]      = meta_rd_data[WAYS + w * RW +: RW];
            tag_lane[w]  = tag_rd_data[w * TW_S +: TW_S];
            act[w]       = (w == 0) || (w < int'(r_wiu));
            hit_vec[w]   = act[w] && valid_row[w] && (tag_lane[w] == r_tag);
            inv_vec[w]   = act[w] && !valid_row[w];
        end
        for (int r = 0; r < WAYS; r++) begin
            for (int w = 0; w < WAYS; w++) begin
                if (act[w] && (rank[w] == RW'(r))) begin
                    rank_seen[r] = 1'b1;
                end
            end
        end
        // Highest rank present among the active ways.
        for (int r = 0; r < WAYS; r++) begin
            if (rank_seen[r]) begin
                max_rank = RW'(r);
            end
        end
        // Lowest-numbered way wins each search.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit     = 1'b1;
                hit_way = RW'(w);
            end
            if (inv_vec[w]) begin
                any_inv = 1'b1;
                inv_way = RW'(w);
            end
            if (act[w] && (rank[w] == max_rank)) begin
                vic_way = RW'(w);
            end
        end
    end

    assign fill_all = !hit && any_inv;
    assign used     = hit ? hit_way : (any_inv ? inv_way : vic_way);
    assign old_rank = rank[used];

    // Recency update and new row contents.
    always_comb begin
        tag_wr_data = tag_rd_data;
        for (int w = 0; w < WAYS; w++) begin
            new_valid[w] = valid_row[w] || (RW'(w) == used);
            if (RW'(w) == used) begin
                new_rank[w] = '0;
            end else if (act[w] && valid_row[w] && (fill_all || (rank[w] < old_rank))
                         && (rank[w] != RW'(WAYS - 1))) begin
                new_rank[w] = rank[w] + RW'(1);
            end else begin
                new_rank[w] = rank[w];
            end
        end
        tag_wr_data[used * TW_S +: TW_S] = r_tag;
        meta_wr_data = '0;
        if (!i_cmd.clr_en) begin
            meta_wr_data[WAYS-1:0] = new_valid;
            for (int w = 0; w < WAYS; w++) begin
                meta_wr_data[WAYS + w * RW +: RW] = new_rank[w];
            end
        end
    end

    assign meta_wr_en = i_cmd.clr_en | i_cmd.lookup;
    assign tag_wr_en  = i_cmd.lookup & !hit;

    // Valid bits and recency ranks, one row per set.
    sacl_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (meta_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (meta_rd_data)
    );

    // Tags, one row per set.
    sacl_ram #(
        .WIDTH (TAGROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (tag_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (tag_rd_data)
    );

    // Saturating access and miss counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_miss <= '0;
        end else if (i_cmd.lookup) begin
            if (r_acc != '1) begin
                r_acc <= r_acc + CNT_W'(1);
            end
            if (!hit && (r_miss != '1)) begin
                r_miss <= r_miss + CNT_W'(1);
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.lookup;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit     <= hit;
            r_set_out <= SET_OUT_W'(r_set);
        end
    end

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_set_index    = r_set_out;
    assign o_miss_total   = r_miss;
    assign o_access_total = r_acc;

    // A result strobe lasts one cycle, since updates never run back to back.
    `SACL_ASSERT(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "result strobe held for two cycles")
    // Misses can never outnumber accesses.
    `SACL_ASSERT(a_miss_le_acc, i_clk, i_rst_n, r_done |-> (r_miss <= r_acc), "miss count exceeds access count")
    // The way chosen for update is always an active way.
    `SACL_ASSERT(a_used_active, i_clk, i_rst_n, i_cmd.lookup |-> act[used], "update chose an inactive way")

endmodule

// ===== rtl/set_assoc_cache_lru_lookup_top.sv =====
// Top level of the set-associative cache tag lookup with true LRU replacement.
// Depends on sacl_pkg, sacl_ctrl, sacl_dpath and sacl_ram.
//
// Channel   Ports                                            Direction  Handshake
// request   start, i_address                                 in         start && !busy
// config    i_cfg_wr_en, i_cfg_wr_data                       in         i_cfg_wr_en
// result    o_done, o_hit, o_set_index, o_miss_total,        out        o_done strobe
//           o_access_total
//
// With a power-of-two set count the set row is read from the tag and LRU RAMs in
// the accept cycle and updated in the next, through the one write port of each RAM.
// Otherwise a reciprocal multiplication runs in a divide state, the row is read in
// a read state after it and updated last; busy holds off new requests until then.
// After reset a clearing pass zeroes all SETS rows of the LRU RAM; busy is high meanwhile.
// Each result is shown for one cycle, the cycle after the update; the receiver cannot stall.
module set_assoc_cache_lru_lookup_top
    import sacl_pkg::*;
#(
    parameter int SETS        = 64,
    parameter int WAYS        = 8,
    parameter int OFFSET_BITS = 6,
    parameter int ADDR_BITS   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ADDR_PORT_W-1:0] i_address,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    output logic                   o_done,
    output logic                   o_hit,
    output logic [SET_OUT_W-1:0]   o_set_index,
    output logic [CNT_W-1:0]       o_miss_total,
    output logic [CNT_W-1:0]       o_access_total
);

    t_sacl_cmd    cmd;
    t_sacl_status status;

    // Sequencer.
    sacl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Tag store, LRU state and counters.
    sacl_dpath #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_address      (i_address),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_set_index    (o_set_index),
        .o_miss_total   (o_miss_total),
        .o_access_total (o_access_total)
    );

endmodule
